// File: rtl/sbie_pkg.sv
// sbie_pkg: shared constants, opcode codes and controller/datapath bundles
// for the sixteen-bit instruction executor. No dependencies.
package sbie_pkg;

  localparam int CALL_DEPTH_DEF = 16;
  localparam int DATA_WORDS_DEF = 1024;
  localparam int SAVED_REGS     = 15;
  localparam int NREGS          = 64;

  localparam logic [5:0] ZERO_REG   = 6'd63;
  localparam logic [5:0] SLT_REG    = 6'd57;
  localparam logic [5:0] INPUT_REG  = 6'd15;
  localparam logic [5:0] OUTPUT_REG = 6'd16;
  localparam logic [3:0] LAST_SAVED = 4'(SAVED_REGS - 1);

  typedef enum logic [3:0] {
    OP_LOAD    = 4'd0,
    OP_LI      = 4'd1,
    OP_STORE   = 4'd2,
    OP_JUMP    = 4'd3,
    OP_CALL    = 4'd4,
    OP_BEQ     = 4'd5,
    OP_BNE     = 4'd6,
    OP_SHIFT   = 4'd7,
    OP_MOVE    = 4'd8,
    OP_ILLEGAL = 4'd9,
    OP_SLT     = 4'd10,
    OP_RET     = 4'd11,
    OP_ADD     = 4'd12,
    OP_SUB     = 4'd13,
    OP_AND     = 4'd14,
    OP_OR      = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    RF_RS,
    RF_RD,
    RF_IDX
  } rf_sel_t;

  typedef struct packed {
    logic    clr;
    logic    cap_instr;
    rf_sel_t rf_sel;
    logic    cap_a;
    logic    exec;
    logic    ld_fin;
    logic    call_start;
    logic    sv_wr;
    logic    ret_start;
    logic    cap_ret_pc;
    logic    rs_wr;
    logic    fin_sub;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic halt;
    logic full;
    logic empty;
    logic idx_last;
    logic clr_last;
  } dp_sts_t;

endpackage

// File: rtl/sbie_if.sv
// sbie_if: valid/ready channel interfaces for instruction and result words.
// No dependencies.
interface sbie_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [5:0]  src_reg;
  logic [5:0]  dst_reg;
  logic [15:0] immediate;

  modport source(output valid, op, src_reg, dst_reg, immediate, input ready);
  modport sink(input valid, op, src_reg, dst_reg, immediate, output ready);
endinterface

interface sbie_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic        write_enable;
  logic [5:0]  write_reg;
  logic [15:0] write_value;
  logic [15:0] output_reg_value;
  logic        halted;
  logic        error;

  modport source(output valid, next_pc, write_enable, write_reg, write_value,
                 output_reg_value, halted, error, input ready);
  modport sink(input valid, next_pc, write_enable, write_reg, write_value,
               output_reg_value, halted, error, output ready);
endinterface

// File: rtl/sbie_ram.sv
// sbie_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module sbie_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sbie_ctrl.sv
// sbie_ctrl: sequencing state machine for the executor.
// Depends on sbie_pkg.
module sbie_ctrl import sbie_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RA, S_RB, S_EX, S_LD,
    S_SV_RD, S_SV_WR, S_RT_PC, S_RS_RD, S_RS_WR, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    cmd.rf_sel = RF_RS;
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_instr = 1'b1;
          state_nxt     = S_RA;
        end
      end
      S_RA: begin
        state_nxt = S_RB;
      end
      S_RB: begin
        cmd.rf_sel = RF_RD;
        cmd.cap_a  = 1'b1;
        state_nxt  = S_EX;
      end
      S_EX: begin
        cmd.rf_sel = RF_RD;
        if (slot_free) begin
          if (sts.halt) begin
            cmd.exec  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            case (sts.op)
              OP_LOAD: state_nxt = S_LD;
              OP_CALL: begin
                if (sts.full) begin
                  cmd.exec  = 1'b1;
                  state_nxt = S_IDLE;
                end else begin
                  cmd.call_start = 1'b1;
                  state_nxt      = S_SV_RD;
                end
              end
              OP_RET: begin
                if (sts.empty) begin
                  cmd.exec  = 1'b1;
                  state_nxt = S_IDLE;
                end else begin
                  cmd.ret_start = 1'b1;
                  state_nxt     = S_RT_PC;
                end
              end
              default: begin
                cmd.exec  = 1'b1;
                state_nxt = S_IDLE;
              end
            endcase
          end
        end
      end
      S_LD: begin
        cmd.ld_fin = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SV_RD: begin
        cmd.rf_sel = RF_IDX;
        state_nxt  = S_SV_WR;
      end
      S_SV_WR: begin
        cmd.sv_wr = 1'b1;
        state_nxt = sts.idx_last ? S_FIN : S_SV_RD;
      end
      S_RT_PC: begin
        cmd.cap_ret_pc = 1'b1;
        state_nxt      = S_RS_RD;
      end
      S_RS_RD: begin
        state_nxt = S_RS_WR;
      end
      S_RS_WR: begin
        cmd.rs_wr = 1'b1;
        state_nxt = sts.idx_last ? S_FIN : S_RS_RD;
      end
      S_FIN: begin
        cmd.fin_sub = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec || cmd.ld_fin || cmd.fin_sub) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/sbie_dp.sv
// sbie_dp: executor datapath: register file, stacks, data memory, pc and
// result register. Depends on sbie_pkg and sbie_ram.
module sbie_dp import sbie_pkg::*; #(
  parameter int CALL_DEPTH = CALL_DEPTH_DEF,
  parameter int DATA_WORDS = DATA_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic [3:0]  in_op,
  input  logic [5:0]  in_src,
  input  logic [5:0]  in_dst,
  input  logic [15:0] in_imm,
  output logic [15:0] o_next_pc,
  output logic        o_we,
  output logic [5:0]  o_wreg,
  output logic [15:0] o_wval,
  output logic [15:0] o_r16,
  output logic        o_halted,
  output logic        o_error
);

  localparam int DMAW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int RAW  = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
  localparam int DW   = $clog2(CALL_DEPTH + 1);
  localparam int SSD  = CALL_DEPTH * SAVED_REGS;
  localparam int SSAW = (SSD > 1) ? $clog2(SSD) : 1;
  localparam int SPW  = $clog2(SSD + 1);

  // instruction and operands
  op_t         op_r;
  logic [5:0]  src_r, dst_r;
  logic [15:0] imm_r, a_r;
  logic [15:0] pc_r;
  logic        halt_r;
  logic [DW-1:0]  depth_r;
  logic [SPW-1:0] sp_r;
  logic [3:0]     idx_r;
  logic [DMAW-1:0] clr_r;
  logic [15:0] r16_r;

  // register file
  logic        rf_we;
  logic [5:0]  rf_waddr, rf_raddr, rf_raddr_q;
  logic [15:0] rf_wdata, rf_rdata, rf_q;
  logic [NREGS-1:0] vld_r;

  // other memories
  logic [15:0] dm_rdata, rt_rdata, ss_rdata;
  logic        dm_we;
  logic [DMAW-1:0] dm_waddr;
  logic [15:0] dm_wdata;
  logic [15:0] addr;
  logic        in_range;
  logic [SSAW-1:0] ss_addr;

  // step result
  logic        commit;
  logic        x_we, x_err, x_halt;
  logic [5:0]  x_wr;
  logic [15:0] x_wv, x_npc, pc1, pc2, ld_val, r16_nxt;

  function automatic logic [15:0] shift_val(input logic [15:0] v, input logic [15:0] amt);
    logic [15:0] mag;
    mag = amt[15] ? (16'd0 - amt) : amt;
    if (amt == 16'd0) begin
      shift_val = v;
    end else if (mag >= 16'd16) begin
      shift_val = 16'd0;
    end else if (amt[15]) begin
      shift_val = v >> mag[3:0];
    end else begin
      shift_val = v << mag[3:0];
    end
  endfunction

  assign rf_q     = (rf_raddr_q == ZERO_REG || !vld_r[rf_raddr_q]) ? 16'd0 : rf_rdata;
  assign addr     = a_r + imm_r;
  assign in_range = {1'b0, addr} < 17'(DATA_WORDS);
  assign ld_val   = in_range ? dm_rdata : 16'd0;
  assign pc1      = pc_r + 16'd1;
  assign pc2      = pc_r + 16'd2;
  assign ss_addr  = SSAW'(sp_r + SPW'(idx_r));
  assign commit   = cmd.exec || cmd.ld_fin;

  always_comb begin
    case (cmd.rf_sel)
      RF_RS:   rf_raddr = src_r;
      RF_RD:   rf_raddr = dst_r;
      RF_IDX:  rf_raddr = {2'b00, idx_r};
      default: rf_raddr = src_r;
    endcase
  end

  // rf_q holds rd's value during the execute step
  always_comb begin
    x_we   = 1'b0;
    x_wr   = dst_r;
    x_wv   = 16'd0;
    x_npc  = pc_r;
    x_err  = 1'b0;
    x_halt = halt_r;
    if (!halt_r) begin
      case (op_r)
        OP_LOAD:  begin x_we = 1'b1; x_wv = ld_val; x_npc = pc2; end
        OP_LI:    begin x_we = 1'b1; x_wv = imm_r; x_npc = pc2; end
        OP_STORE: x_npc = pc2;
        OP_JUMP: begin
          if (imm_r == pc_r) x_halt = 1'b1;
          else x_npc = imm_r;
        end
        OP_BEQ:   x_npc = (a_r == rf_q) ? imm_r : pc2;
        OP_BNE:   x_npc = (a_r != rf_q) ? imm_r : pc2;
        OP_SHIFT: begin x_we = 1'b1; x_wv = shift_val(a_r, imm_r); x_npc = pc2; end
        OP_MOVE:  begin x_we = 1'b1; x_wv = a_r; x_npc = pc1; end
        OP_SLT: begin
          x_we  = 1'b1;
          x_wr  = SLT_REG;
          x_wv  = {15'd0, $signed(a_r) < $signed(rf_q)};
          x_npc = pc1;
        end
        OP_ADD:   begin x_we = 1'b1; x_wv = rf_q + a_r; x_npc = pc1; end
        OP_SUB:   begin x_we = 1'b1; x_wv = rf_q - a_r; x_npc = pc1; end
        OP_AND:   begin x_we = 1'b1; x_wv = rf_q & a_r; x_npc = pc1; end
        OP_OR:    begin x_we = 1'b1; x_wv = rf_q | a_r; x_npc = pc1; end
        // illegal opcode, full call or empty return reach here only as errors
        default:  begin x_err = 1'b1; x_halt = 1'b1; end
      endcase
    end
  end

  // register file write port
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = INPUT_REG;
    rf_wdata = cfg_wdata;
    if (cfg_we) begin
      rf_we = 1'b1;
    end else if (cmd.rs_wr) begin
      rf_we    = 1'b1;
      rf_waddr = {2'b00, idx_r};
      rf_wdata = ss_rdata;
    end else if (commit && x_we) begin
      rf_we    = 1'b1;
      rf_waddr = x_wr;
      rf_wdata = x_wv;
    end
  end

  assign r16_nxt = (rf_we && rf_waddr == OUTPUT_REG) ? rf_wdata : r16_r;

  // data memory write port: clear sweep after reset, then stores
  always_comb begin
    dm_we    = 1'b0;
    dm_waddr = addr[DMAW-1:0];
    dm_wdata = rf_q;
    if (cmd.clr) begin
      dm_we    = 1'b1;
      dm_waddr = clr_r;
      dm_wdata = 16'd0;
    end else if (cmd.exec && !halt_r && op_r == OP_STORE && in_range) begin
      dm_we = 1'b1;
    end
  end

  sbie_ram #(.WIDTH(16), .DEPTH(NREGS)) u_rf (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata)
  );

  sbie_ram #(.WIDTH(16), .DEPTH(DATA_WORDS)) u_dm (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .raddr(addr[DMAW-1:0]), .rdata(dm_rdata)
  );

  sbie_ram #(.WIDTH(16), .DEPTH(CALL_DEPTH)) u_rt (
    .clk(clk), .we(cmd.call_start), .waddr(depth_r[RAW-1:0]), .wdata(pc2),
    .raddr(RAW'(depth_r - DW'(1))), .rdata(rt_rdata)
  );

  sbie_ram #(.WIDTH(16), .DEPTH(SSD)) u_ss (
    .clk(clk), .we(cmd.sv_wr), .waddr(ss_addr), .wdata(rf_q),
    .raddr(ss_addr), .rdata(ss_rdata)
  );

  // payload registers
  always_ff @(posedge clk) begin
    rf_raddr_q <= rf_raddr;
    if (cmd.cap_instr) begin
      op_r  <= op_t'(in_op);
      src_r <= in_src;
      dst_r <= in_dst;
      imm_r <= in_imm;
    end
    if (cmd.cap_a) a_r <= rf_q;
    if (commit) begin
      o_next_pc <= x_npc;
      o_we      <= x_we;
      o_wreg    <= x_we ? x_wr : 6'd0;
      o_wval    <= x_we ? x_wv : 16'd0;
      o_r16     <= r16_nxt;
      o_halted  <= x_halt;
      o_error   <= x_err;
    end else if (cmd.fin_sub) begin
      o_next_pc <= pc_r;
      o_we      <= 1'b0;
      o_wreg    <= 6'd0;
      o_wval    <= 16'd0;
      o_r16     <= r16_r;
      o_halted  <= halt_r;
      o_error   <= 1'b0;
    end
  end

  // architectural control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= 16'd0;
      halt_r  <= 1'b0;
      depth_r <= '0;
      sp_r    <= '0;
      idx_r   <= 4'd0;
      clr_r   <= '0;
      r16_r   <= 16'd0;
      vld_r   <= '0;
    end else begin
      r16_r <= r16_nxt;
      if (rf_we) vld_r[rf_waddr] <= 1'b1;
      if (cmd.clr) clr_r <= clr_r + DMAW'(1);
      if (commit) begin
        pc_r   <= x_npc;
        halt_r <= x_halt;
      end
      if (cmd.call_start) begin
        pc_r  <= imm_r;
        idx_r <= 4'd0;
      end
      if (cmd.ret_start) begin
        depth_r <= depth_r - DW'(1);
        sp_r    <= sp_r - SPW'(SAVED_REGS);
        idx_r   <= 4'd0;
      end
      if (cmd.cap_ret_pc) pc_r <= rt_rdata;
      if (cmd.sv_wr || cmd.rs_wr) idx_r <= idx_r + 4'd1;
      if (cmd.sv_wr && idx_r == LAST_SAVED) begin
        depth_r <= depth_r + DW'(1);
        sp_r    <= sp_r + SPW'(SAVED_REGS);
      end
    end
  end

  assign sts.op       = op_r;
  assign sts.halt     = halt_r;
  assign sts.full     = (depth_r == DW'(CALL_DEPTH));
  assign sts.empty    = (depth_r == '0);
  assign sts.idx_last = (idx_r == LAST_SAVED);
  assign sts.clr_last = (clr_r == DMAW'(DATA_WORDS - 1));

endmodule

// File: rtl/sixteen_bit_instruction_executor_top.sv
// Top level of the sixteen-bit instruction executor.
// Depends on sbie_pkg, sbie_if, sbie_ram, sbie_ctrl and sbie_dp.

// Executes one pre-fetched instruction word per accepted input and returns
// one result word (next pc, register write, register 16, halt, error).
// After reset the data memory is swept to zero, one word a cycle, over all
// DATA_WORDS words (1024 by default); no instruction is accepted until the
// sweep ends, though cfg writes are taken. An ordinary instruction steps
// through accept, read rs, read rd and execute, set by the single read
// port of the register file, and waits in execute while the previous result
// is untaken; a load adds a step for the data memory read. Call and return
// move registers 0..14 to or from the save stack, a read step and a write
// step per register. The result sits in an output register, so the next word
// is accepted while the previous result waits to be taken.
module sixteen_bit_instruction_executor_top import sbie_pkg::*; #(
  parameter int CALL_DEPTH = CALL_DEPTH_DEF,
  parameter int DATA_WORDS = DATA_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  sbie_in_if.sink          in_ch,
  sbie_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: owns the handshakes and walks each instruction's steps
  sbie_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  // datapath: all architectural state and the result register
  sbie_dp #(.CALL_DEPTH(CALL_DEPTH), .DATA_WORDS(DATA_WORDS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_op(in_ch.op), .in_src(in_ch.src_reg), .in_dst(in_ch.dst_reg),
    .in_imm(in_ch.immediate),
    .o_next_pc(out_ch.next_pc), .o_we(out_ch.write_enable),
    .o_wreg(out_ch.write_reg), .o_wval(out_ch.write_value),
    .o_r16(out_ch.output_reg_value), .o_halted(out_ch.halted),
    .o_error(out_ch.error)
  );

  // an error always leaves the block halted
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.error |-> out_ch.halted)
    else $error("error reported without halt");

  // no write reported means zero write fields
  a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.write_enable |->
      (out_ch.write_reg == 6'd0 && out_ch.write_value == 16'd0))
    else $error("write fields set without write");

  // one word in flight: intake closes right after acceptance
  a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second word accepted while busy");

endmodule
